### src/shmp_pkg.sv
package shmp_pkg;

  localparam int unsigned SumW  = 31;
  localparam int unsigned ByteW = 8;
  localparam int unsigned FoldW = SumW + ByteW;
  localparam int unsigned HiW   = FoldW - SumW;
  localparam int unsigned ProdW = HiW + 5;

  // p = 2^31 - 19, so 2^31 folds back in as 19
  localparam logic [SumW-1:0]  HashPrime = 31'd2147483629;
  localparam logic [ProdW-1:0] FoldMul   = 13'd19;

endpackage

### src/shmp_fold.sv
module shmp_fold import shmp_pkg::*; (
  input  logic [SumW-1:0]  sum_i,
  input  logic [ByteW-1:0] byte_i,
  output logic [SumW-1:0]  sum_o
);

  logic [FoldW-1:0] wide;
  logic [HiW-1:0]   hi;
  logic [ProdW-1:0] prod;
  logic [SumW:0]    part;
  logic [SumW:0]    diff;

  always_comb begin
    wide = {sum_i, byte_i};
    hi   = wide[FoldW-1:SumW];
    // hi * 19 stays below 2^13
    prod = ProdW'(hi) * FoldMul;
    // part < 2p, one conditional subtract finishes the reduction
    part = {1'b0, wide[SumW-1:0]} + (SumW+1)'(prod);
    diff = part - {1'b0, HashPrime};
    if (part >= {1'b0, HashPrime}) begin
      sum_o = diff[SumW-1:0];
    end else begin
      sum_o = part[SumW-1:0];
    end
  end

endmodule

### src/string_hash_mod_prime.sv
// string_hash_mod_prime: running hash (sum*256 + byte) mod 2^31-19, one byte per word.
// Path: an accepted word is held in the input register; a string's last word then loads the result register.
// Throughput: one word per cycle unless a last word waits on a stalled result slot; the fold of a byte
// (multiply by 19, add, conditional subtract) lies between the input register and the running sum register.
// Reset: rst_ni asynchronous active low; clears valid flags and the running sum.
module string_hash_mod_prime import shmp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ByteW-1:0] byte_value_i,
  input  logic             byte_present_i,
  input  logic             last_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [SumW-1:0]  hash_value_o
);

  // input register
  logic             in_vld_q;
  logic [ByteW-1:0] byte_q;
  logic             present_q;
  logic             last_q;

  // running sum and result register
  logic [SumW-1:0] sum_q, sum_d;
  logic            out_vld_q;
  logic [SumW-1:0] hash_q;

  logic [SumW-1:0] folded;
  logic            out_free;
  logic            work_fire;
  logic            in_take;

  shmp_fold u_fold (
    .sum_i  (sum_q),
    .byte_i (byte_q),
    .sum_o  (folded)
  );

  // The result slot is free when empty or being drained this cycle.
  assign out_free  = !out_vld_q || !out_stall_i;
  // A word that ends no string needs no result slot.
  assign work_fire = in_vld_q && (!last_q || out_free);
  // Input register can reload when empty or when its word moves on.
  assign in_stall_o = in_vld_q && !work_fire;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    sum_d = present_q ? folded : sum_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      sum_q     <= '0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (work_fire) begin
        in_vld_q <= 1'b0;
      end
      if (work_fire) begin
        // string end clears the sum for the next string
        sum_q <= last_q ? '0 : sum_d;
      end
      if (work_fire && last_q) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      byte_q    <= byte_value_i;
      present_q <= byte_present_i;
      last_q    <= last_item_i;
    end
    if (work_fire && last_q) begin
      // sum_d < p, so +1 cannot wrap 31 bits
      hash_q <= sum_d + SumW'(1);
    end
  end

  assign out_valid_o  = out_vld_q;
  assign hash_value_o = hash_q;

endmodule

### src/shmp_checker.sv
module shmp_checker import shmp_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic [ByteW-1:0] byte_value_i,
  input logic             byte_present_i,
  input logic             last_item_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [SumW-1:0]  hash_value_o
);

  // stalled input word holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i &&
      $stable({byte_value_i, byte_present_i, last_item_i}))
    else $error("stalled input word changed");

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(hash_value_o))
    else $error("stalled result word changed");

  // hash is sum + 1, never zero
  a_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> hash_value_o != '0)
    else $error("hash of zero");

  // sum stays below the prime
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> hash_value_o <= HashPrime)
    else $error("hash above prime");

  // reset empties the result slot
  a_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result valid in reset");

endmodule

bind string_hash_mod_prime shmp_checker u_shmp_checker (.*);
